FILE: design/ili_pkg.sv
// ----------------------------------------------------------------------------
// ili_pkg
// Shared types and codes of the indexed list: request and result payloads,
// request kinds, status codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ili_pkg;

	// request kinds
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_GET    = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_NULL  = 2'd3;

	// request payload
	typedef struct packed {
		logic [1:0]  req_type;
		logic [6:0]  position;
		logic [31:0] value;
	} ili_req_t;

	// result payload
	typedef struct packed {
		logic [31:0] read_value;
		logic [1:0]  status;
		logic [6:0]  count_after;
	} ili_res_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_GET_WAIT,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INS_WR,
		ST_DONE
	} ili_state_t;

	// controller to datapath
	typedef struct packed {
		logic take_req;
		logic eval;
		logic get_rd;
		logic get_done;
		logic shift_rd;
		logic shift_wr;
		logic ins_wr;
		logic del_done;
		logic push;
	} ili_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic reject;
		logic kind_get;
		logic kind_ins;
		logic shift_none;
		logic shift_end;
		logic out_free;
	} ili_stat_t;

endpackage

FILE: design/ili_stream_if.sv
// ----------------------------------------------------------------------------
// ili_stream_if
// Valid/ready channel with a typed payload; one transfer at each clock edge
// where valid and ready are both high.
// ----------------------------------------------------------------------------
interface ili_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: design/ili_ram.sv
// ----------------------------------------------------------------------------
// ili_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ili_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: design/ili_ctrl.sv
// ----------------------------------------------------------------------------
// ili_ctrl
// Request sequencer: takes a request, walks the entry moves of an insert or
// delete one read and one write at a time, then hands the result out.
// ----------------------------------------------------------------------------
module ili_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ili_pkg::ili_stat_t  stat,
	output ili_pkg::ili_cmd_t   cmd
);
	ili_pkg::ili_state_t state_q;
	ili_pkg::ili_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ili_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ili_pkg::ST_IDLE: begin
				if (req_valid) state_d = ili_pkg::ST_EXEC;
			end
			ili_pkg::ST_EXEC: begin
				if (stat.reject) begin
					state_d = ili_pkg::ST_DONE;
				end else if (stat.kind_get) begin
					state_d = ili_pkg::ST_GET_WAIT;
				end else if (stat.shift_none) begin
					state_d = stat.kind_ins ? ili_pkg::ST_INS_WR : ili_pkg::ST_DONE;
				end else begin
					state_d = ili_pkg::ST_SHIFT_RD;
				end
			end
			ili_pkg::ST_GET_WAIT: state_d = ili_pkg::ST_DONE;
			ili_pkg::ST_SHIFT_RD: state_d = ili_pkg::ST_SHIFT_WR;
			ili_pkg::ST_SHIFT_WR: begin
				if (!stat.shift_end) begin
					state_d = ili_pkg::ST_SHIFT_RD;
				end else begin
					state_d = stat.kind_ins ? ili_pkg::ST_INS_WR : ili_pkg::ST_DONE;
				end
			end
			ili_pkg::ST_INS_WR: state_d = ili_pkg::ST_DONE;
			ili_pkg::ST_DONE: begin
				if (stat.out_free) state_d = ili_pkg::ST_IDLE;
			end
			default: state_d = ili_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			ili_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.take_req = req_valid;
			end
			ili_pkg::ST_EXEC: begin
				cmd.eval = 1'b1;
				cmd.get_rd = !stat.reject && stat.kind_get;
				cmd.del_done = !stat.reject && !stat.kind_get && !stat.kind_ins &&
					stat.shift_none;
			end
			ili_pkg::ST_GET_WAIT: cmd.get_done = 1'b1;
			ili_pkg::ST_SHIFT_RD: cmd.shift_rd = 1'b1;
			ili_pkg::ST_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				cmd.del_done = stat.shift_end && !stat.kind_ins;
			end
			ili_pkg::ST_INS_WR: cmd.ins_wr = 1'b1;
			ili_pkg::ST_DONE: cmd.push = stat.out_free;
			default: cmd = '0;
		endcase
	end

	// sequencing checks
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ili_pkg::ST_DONE && stat.out_free) |=> state_q == ili_pkg::ST_IDLE)
		else $error("result handed out but controller did not return to idle");
	a_ins_wr_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |=> (state_q == ili_pkg::ST_DONE && !req_ready))
		else $error("insert write not followed by result stage");
endmodule

FILE: design/ili_dpath.sv
// ----------------------------------------------------------------------------
// ili_dpath
// Datapath of the indexed list: request registers, range checks, entry
// count, move cursor, entry RAM and the result output register.
// ----------------------------------------------------------------------------
module ili_dpath #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ili_pkg::ili_req_t  req_data,
	input  ili_pkg::ili_cmd_t  cmd,
	output ili_pkg::ili_stat_t stat,
	output logic               res_valid,
	input  logic               res_ready,
	output ili_pkg::ili_res_t  res_data
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 7) ? CW : 7;

	logic [1:0]            type_q;
	logic [PW-1:0]         pos_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         idx_q;
	logic [1:0]            stat_q;
	logic [31:0]           rd_q;
	ili_pkg::ili_res_t     res_q;
	logic                  res_valid_q;

	logic [63:0]           value_ext;
	logic [63:0]           rdata_ext;
	logic [63:0]           count_ext;
	logic [PW-1:0]         cnt_x;
	logic [1:0]            chk_stat;
	logic                  is_ins;
	logic                  is_get;
	logic                  is_del;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign value_ext = 64'(req_data.value);
	assign rdata_ext = 64'(ram_rdata);
	assign count_ext = 64'(count_q);
	assign cnt_x     = PW'(count_q);
	assign is_ins    = (type_q == ili_pkg::REQ_INSERT);
	assign is_get    = (type_q == ili_pkg::REQ_GET);
	assign is_del    = (type_q == ili_pkg::REQ_DELETE);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			type_q <= req_data.req_type;
			pos_q  <= PW'(req_data.position);
			word_q <= value_ext[DATA_WIDTH-1:0];
		end
	end

	// request checks
	always_comb begin
		chk_stat = ili_pkg::STAT_OK;
		if (is_ins) begin
			if (word_q == '0) begin
				chk_stat = ili_pkg::STAT_NULL;
			end else if (pos_q > cnt_x) begin
				chk_stat = ili_pkg::STAT_RANGE;
			end else if (count_q == CW'(DEPTH)) begin
				chk_stat = ili_pkg::STAT_FULL;
			end
		end else if (is_get || is_del) begin
			if (pos_q >= cnt_x) chk_stat = ili_pkg::STAT_RANGE;
		end
	end

	// status to controller
	always_comb begin
		stat.reject     = (chk_stat != ili_pkg::STAT_OK) || !(is_ins || is_get || is_del);
		stat.kind_get   = is_get;
		stat.kind_ins   = is_ins;
		stat.shift_none = is_ins ? (cnt_x == pos_q) :
			((PW + 1)'(pos_q) + (PW + 1)'(1) == (PW + 1)'(cnt_x));
		stat.shift_end  = is_ins ?
			((PW + 1)'(idx_q) == (PW + 1)'(pos_q) + (PW + 1)'(1)) :
			((PW + 1)'(idx_q) + (PW + 1)'(2) == (PW + 1)'(cnt_x));
		stat.out_free   = !res_valid_q || res_ready;
	end

	// result staging and move cursor
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			stat_q <= chk_stat;
			rd_q   <= '0;
			idx_q  <= is_ins ? count_q[AW-1:0] : pos_q[AW-1:0];
		end
		if (cmd.get_done) begin
			rd_q <= rdata_ext[31:0];
		end
		if (cmd.shift_wr) begin
			idx_q <= is_ins ? idx_q - AW'(1) : idx_q + AW'(1);
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins_wr) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.del_done) begin
			count_q <= count_q - CW'(1);
		end
	end

	// entry ram ports
	always_comb begin
		ram_re    = cmd.get_rd || cmd.shift_rd;
		ram_raddr = cmd.get_rd ? pos_q[AW-1:0] :
			(is_ins ? idx_q - AW'(1) : idx_q + AW'(1));
		ram_we    = cmd.shift_wr || cmd.ins_wr;
		ram_waddr = cmd.ins_wr ? pos_q[AW-1:0] : idx_q;
		ram_wdata = cmd.ins_wr ? word_q : ram_rdata;
	end

	ili_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.push) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			res_q.read_value  <= rd_q;
			res_q.status      <= stat_q;
			res_q.count_after <= count_ext[6:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// datapath checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above capacity");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == $past(count_q) + CW'(1)) ||
			(count_q == $past(count_q) - CW'(1)))
		else $error("entry count moved by more than one");
	a_move_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_wr |-> CW'(idx_q) <= count_q)
		else $error("entry move outside the list");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!res_valid_q || res_ready))
		else $error("result overwritten before transfer");
endmodule

FILE: design/indexed_list_insert_delete.sv
// A request is taken in idle and checked in exec. A rejected or ignored
// request then goes to the result stage, a get waits for its RAM read, and
// an insert or delete walks its entry moves, an insert then writing the new
// word. The next request can transfer in the cycle after the result register
// loads. Each moved entry takes one RAM read and one RAM write. Reset
// clears the entry count and the result valid; entry contents are left as is.
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of data words with insert, get and delete at a position;
// controller, datapath and entry RAM.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input logic          clk,
	input logic          arst_n,
	ili_stream_if.sink   req,
	ili_stream_if.source res
);
	ili_pkg::ili_cmd_t  cmd;
	ili_pkg::ili_stat_t stat;
	logic               req_ready;
	logic               res_valid;
	ili_pkg::ili_res_t  res_data;

	ili_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ili_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res_ready (res.ready),
		.res_data  (res_data)
	);

	assign req.ready = req_ready;
	assign res.valid = res_valid;
	assign res.data  = res_data;
endmodule

FILE: dv/ili_list_checker.sv
// ----------------------------------------------------------------------------
// ili_list_checker
// Watches the request and result channels of the indexed list, keeps its own
// copy of the list contents and count, works out the result of every
// accepted request and compares each accepted result with the oldest one
// still awaited. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module ili_list_checker #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  ili_pkg::ili_req_t req_data,
	input  logic              res_valid,
	input  logic              res_ready,
	input  ili_pkg::ili_res_t res_data,
	output int                errors,
	output int                pending,
	output int                list_size,
	output int                checked,
	output int                full_seen
);

	// shadow list contents and fill level
	logic [DATA_WIDTH-1:0] list_words [DEPTH];
	int                    word_count;

	// results still owed by the block, oldest first
	ili_pkg::ili_res_t awaited_results[$];
	ili_pkg::ili_res_t oldest;

	// apply one request to the shadow list and return its result
	function automatic ili_pkg::ili_res_t apply_request(ili_pkg::ili_req_t rq);
		ili_pkg::ili_res_t     r;
		int                    p;
		int                    i;
		logic [DATA_WIDTH-1:0] w;
		r = '0;
		r.status = ili_pkg::STAT_OK;
		p = int'(rq.position);
		w = rq.value[DATA_WIDTH-1:0];
		case (rq.req_type)
			ili_pkg::REQ_INSERT: begin
				// null check wins over range, range over full
				if (w == '0) begin
					r.status = ili_pkg::STAT_NULL;
				end else if (p > word_count) begin
					r.status = ili_pkg::STAT_RANGE;
				end else if (word_count >= DEPTH) begin
					r.status = ili_pkg::STAT_FULL;
				end else begin
					for (i = word_count; i > p; i--)
						list_words[i] = list_words[i-1];
					list_words[p] = w;
					word_count++;
				end
			end
			ili_pkg::REQ_GET: begin
				if (p < word_count && p < DEPTH)
					r.read_value = 32'(list_words[p]);
				else
					r.status = ili_pkg::STAT_RANGE;
			end
			ili_pkg::REQ_DELETE: begin
				if (p >= word_count) begin
					r.status = ili_pkg::STAT_RANGE;
				end else begin
					for (i = p; i + 1 < word_count; i++)
						list_words[i] = list_words[i+1];
					word_count--;
				end
			end
			default: begin
				// unused kind: nothing changes
			end
		endcase
		r.count_after = word_count[6:0];
		return r;
	endfunction

	// predict on request transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_results.delete();
			word_count = 0;
			errors     = 0;
			checked    = 0;
			full_seen  = 0;
			pending    = 0;
			list_size  = 0;
		end else begin
			if (req_valid && req_ready)
				awaited_results.push_back(apply_request(req_data));
			if (res_valid && res_ready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result read_value=%h status=%0d count=%0d",
							$realtime, res_data.read_value, res_data.status,
							res_data.count_after);
				end else begin
					oldest = awaited_results.pop_front();
					checked++;
					if (oldest.status == ili_pkg::STAT_FULL)
						full_seen++;
					if (res_data.read_value !== oldest.read_value ||
						res_data.status !== oldest.status ||
						res_data.count_after !== oldest.count_after) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: result mismatch: exp read_value=%h status=%0d count=%0d",
								$realtime, oldest.read_value, oldest.status,
								oldest.count_after);
							$display("%0t:                  got read_value=%h status=%0d count=%0d",
								$realtime, res_data.read_value, res_data.status,
								res_data.count_after);
						end
					end
				end
			end
			pending   = awaited_results.size();
			list_size = word_count;
		end
	end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the indexed list with a short directed sequence of edge cases, then
// with long random phases that fill, churn and drain the list, with random
// stalls on both channels. Checking is done by ili_list_checker.
// ----------------------------------------------------------------------------
module testbench;
	import ili_pkg::*;

	localparam int DEPTH        = 64;
	localparam int DATA_WIDTH   = 32;
	localparam int RANDOM_ITEMS = 1600;
	localparam int TAIL_ITEMS   = 150;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic clk;
	logic arst_n;
	bit   quiet_tail;
	int   cycle_count;
	int   errors, pending, list_size, checked, full_seen;

	ili_stream_if #(.T(ili_req_t)) req_if ();
	ili_stream_if #(.T(ili_res_t)) res_if ();

	indexed_list_insert_delete #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if)
	);

	ili_list_checker #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_if.valid),
		.req_ready (req_if.ready),
		.req_data  (req_if.data),
		.res_valid (res_if.valid),
		.res_ready (res_if.ready),
		.res_data  (res_if.data),
		.errors    (errors),
		.pending   (pending),
		.list_size (list_size),
		.checked   (checked),
		.full_seen (full_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still awaited",
				cycle_count, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: random stall bursts, with calm stretches
	initial begin
		int stall_left;
		int segment_left;
		bit calm;
		stall_left   = 0;
		segment_left = 0;
		calm         = 1'b0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (segment_left == 0) begin
				segment_left = $urandom_range(50, 300);
				calm = ($urandom_range(0, 3) == 0);
			end
			segment_left--;
			if (stall_left > 0 && !quiet_tail) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				res_if.ready <= 1'b1;
				stall_left = 0;
				if (!calm && !quiet_tail && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 3);
			end
		end
	end

	// one request transfer, with an optional idle burst in front
	task automatic send_request(input logic [1:0] kind, input logic [6:0] pos,
		input logic [31:0] word, input bit may_idle);
		ili_req_t rq;
		int       gap;
		gap = 0;
		if (may_idle && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 3);
		repeat (gap) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
		end
		rq.req_type = kind;
		rq.position = pos;
		rq.value    = word;
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.data  <= rq;
		do @(posedge clk); while (!req_if.ready);
	endtask

	// hold the sender until the block has answered everything
	task automatic wait_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// stimulus
	initial begin
		int          real_items;
		int          ignored_items;
		int          peak_size;
		int          phase_left;
		int          phase_mode;
		int          calm_left;
		bit          tx_calm;
		int          roll;
		logic [1:0]  kind;
		logic [6:0]  pos;
		logic [31:0] word;

		arst_n       = 1'b0;
		quiet_tail   = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty list, rejects, ends, middle, ignored kind
		send_request(REQ_GET,    7'd0,   32'h1234_5678, 1'b0);
		send_request(REQ_DELETE, 7'd0,   32'h0,         1'b0);
		send_request(REQ_INSERT, 7'd0,   32'h0,         1'b0);
		send_request(REQ_INSERT, 7'd1,   32'h0000_0001, 1'b0);
		send_request(REQ_INSERT, 7'd127, 32'hFFFF_FFFF, 1'b0);
		send_request(REQ_INSERT, 7'd127, 32'h0,         1'b0);
		send_request(REQ_INSERT, 7'd0,   32'hFFFF_FFFF, 1'b0);
		send_request(REQ_INSERT, 7'd1,   32'h0000_0001, 1'b0);
		send_request(REQ_INSERT, 7'd0,   32'h8000_0000, 1'b0);
		send_request(REQ_INSERT, 7'd1,   32'h5A5A_A5A5, 1'b0);
		send_request(REQ_GET,    7'd0,   32'h0,         1'b0);
		send_request(REQ_GET,    7'd1,   32'h0,         1'b0);
		send_request(REQ_GET,    7'd2,   32'h0,         1'b0);
		send_request(REQ_GET,    7'd3,   32'h0,         1'b0);
		send_request(REQ_GET,    7'd4,   32'h0,         1'b0);
		send_request(2'd3,       7'd127, 32'hFFFF_FFFF, 1'b0);
		send_request(REQ_GET,    7'd64,  32'h0,         1'b0);
		send_request(REQ_DELETE, 7'd4,   32'h0,         1'b0);
		send_request(REQ_DELETE, 7'd1,   32'h0,         1'b0);
		send_request(REQ_DELETE, 7'd2,   32'h0,         1'b0);
		send_request(REQ_DELETE, 7'd0,   32'h0,         1'b0);
		send_request(REQ_GET,    7'd0,   32'h0,         1'b0);
		wait_drained();

		// random: phases biased to fill, churn or drain the list
		real_items    = 0;
		ignored_items = 0;
		peak_size     = 0;
		phase_left    = 0;
		phase_mode    = 0;
		calm_left     = 0;
		tx_calm       = 1'b0;
		while (real_items < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(100, 180);
				phase_mode = (real_items == 0) ? 0 : $urandom_range(0, 2);
			end
			phase_left--;
			if (calm_left == 0) begin
				calm_left = $urandom_range(20, 80);
				tx_calm = ($urandom_range(0, 3) == 0);
			end
			calm_left--;
			if (real_items == RANDOM_ITEMS - TAIL_ITEMS)
				quiet_tail = 1'b1;
			if (real_items == RANDOM_ITEMS / 2)
				wait_drained();

			// request kind
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 49) == 0)
				kind = 2'd3;
			else if (phase_mode == 0)
				kind = (roll < 70) ? REQ_INSERT : (roll < 85) ? REQ_GET : REQ_DELETE;
			else if (phase_mode == 1)
				kind = (roll < 15) ? REQ_INSERT : (roll < 35) ? REQ_GET : REQ_DELETE;
			else
				kind = (roll < 35) ? REQ_INSERT : (roll < 70) ? REQ_GET : REQ_DELETE;

			// position: mostly legal, some at the boundaries, some anywhere
			roll = $urandom_range(0, 19);
			if (roll == 0)
				pos = 7'($urandom_range(0, 127));
			else if (roll == 1)
				pos = 7'(list_size);
			else if (roll == 2)
				pos = 7'd0;
			else if (roll == 3 && list_size > 0)
				pos = 7'(list_size - 1);
			else if (kind == REQ_INSERT)
				pos = 7'($urandom_range(0, list_size));
			else if (list_size > 0)
				pos = 7'($urandom_range(0, list_size - 1));
			else
				pos = 7'd0;

			// value: mostly random, some null, some all ones
			roll = $urandom_range(0, 29);
			if (roll == 0)
				word = 32'h0;
			else if (roll == 1)
				word = 32'hFFFF_FFFF;
			else
				word = $urandom;

			send_request(kind, pos, word, !tx_calm && !quiet_tail);
			if (kind == 2'd3)
				ignored_items++;
			else
				real_items++;
			if (list_size > peak_size)
				peak_size = list_size;
		end

		// drain and let any stray result show up
		wait_drained();
		repeat (20) @(negedge clk);

		$display("covered %0d random requests plus %0d of the unused kind, %0d results checked",
			real_items, ignored_items, checked);
		$display("list peaked at %0d of %0d entries, %0d inserts rejected as full",
			peak_size, DEPTH, full_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
